// ===== hw/rtl/ltrc_pkg.sv =====
// ltrc_pkg: shared types, operator codes and character constants for the
// left-to-right calculator parser; no dependencies

package ltrc_pkg;

   localparam int CHAR_WIDTH  = 8;
   localparam int VALUE_WIDTH = 64;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_type;

   localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO = 8'h30;
   localparam logic [CHAR_WIDTH-1:0] CHAR_NINE = 8'h39;
   localparam logic [CHAR_WIDTH-1:0] CHAR_SUB  = 8'h53;
   localparam logic [CHAR_WIDTH-1:0] CHAR_MUL  = 8'h4d;
   localparam logic [CHAR_WIDTH-1:0] CHAR_DIV  = 8'h55;
   localparam logic [CHAR_WIDTH-1:0] CHAR_ADD  = 8'h50;

   typedef struct packed {
      logic   start;
      op_type op;
   } unit_cmd_type;

   typedef struct packed {
      logic done;
      logic ovf;
      logic dz;
   } unit_sts_type;

   function automatic logic is_digit(input logic [CHAR_WIDTH-1:0] c);
      return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
   endfunction

endpackage

// ===== hw/rtl/ltrc_req_if.sv =====
// ltrc_req_if: request channel, one character per request
// depends on ltrc_pkg

interface ltrc_req_if;
   logic                            valid;
   logic                            ready;
   logic [ltrc_pkg::CHAR_WIDTH-1:0] char_code;

   modport source (output valid, output char_code, input ready);
   modport sink   (input valid, input char_code, output ready);
endinterface

// ===== hw/rtl/ltrc_rsp_if.sv =====
// ltrc_rsp_if: result channel, accumulator value and sticky flags
// depends on ltrc_pkg

interface ltrc_rsp_if;
   logic                                    valid;
   logic                                    ready;
   logic signed [ltrc_pkg::VALUE_WIDTH-1:0] value;
   logic                                    divide_by_zero;
   logic                                    overflow;

   modport source (output valid, output value, output divide_by_zero, output overflow,
                   input ready);
   modport sink   (input valid, input value, input divide_by_zero, input overflow,
                   output ready);
endinterface

// ===== hw/rtl/ltrc_unit.sv =====
// ltrc_unit: shared adder under a small sequencer; add, subtract, shift-add
// multiply and restoring divide on signed operands
// depends on ltrc_pkg

module ltrc_unit #(
   parameter int ACC_WIDTH = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ltrc_pkg::unit_cmd_type cmd,
   input  logic [ACC_WIDTH-1:0]   opa,
   input  logic [ACC_WIDTH-1:0]   opb,
   output ltrc_pkg::unit_sts_type sts,
   output logic [ACC_WIDTH-1:0]   result
);
   import ltrc_pkg::*;

   localparam int CW = $clog2(ACC_WIDTH);

   typedef enum logic [6:0] {
      U_IDLE  = 7'b0000001,
      U_ARITH = 7'b0000010,
      U_ABSA  = 7'b0000100,
      U_ABSB  = 7'b0001000,
      U_ITER  = 7'b0010000,
      U_FIX   = 7'b0100000,
      U_DONE  = 7'b1000000
   } ustate_type;

   ustate_type           state_ff, state_in;
   op_type               op_ff, op_in;
   logic                 neg_ff, neg_in;
   logic                 ovf_ff, ovf_in;
   logic                 dz_ff, dz_in;
   logic [ACC_WIDTH-1:0] ra_ff, ra_in;
   logic [ACC_WIDTH-1:0] rb_ff, rb_in;
   logic [ACC_WIDTH-1:0] hi_ff, hi_in;
   logic [CW-1:0]        cnt_ff, cnt_in;

   logic [ACC_WIDTH-1:0] add_x, add_y, add_yeff;
   logic                 add_sub;
   logic [ACC_WIDTH:0]   add_sum;
   logic                 arith_ovf;
   logic                 qbit;

   // the one shared adder
   assign add_yeff  = add_sub ? ~add_y : add_y;
   assign add_sum   = {1'b0, add_x} + {1'b0, add_yeff} + (ACC_WIDTH+1)'(add_sub);
   assign arith_ovf = (add_x[ACC_WIDTH-1] == add_yeff[ACC_WIDTH-1]) &&
                      (add_sum[ACC_WIDTH-1] != add_x[ACC_WIDTH-1]);
   assign qbit      = add_sum[ACC_WIDTH];

   always_comb begin
      add_x   = '0;
      add_y   = '0;
      add_sub = 1'b0;
      unique case (state_ff)
         U_ARITH: begin
            add_x   = ra_ff;
            add_y   = rb_ff;
            add_sub = (op_ff == OP_SUB);
         end
         U_ABSA: begin
            add_y   = ra_ff;
            add_sub = 1'b1;
         end
         U_ABSB: begin
            add_y   = rb_ff;
            add_sub = 1'b1;
         end
         U_ITER: begin
            add_y = rb_ff;
            if (op_ff == OP_MUL) begin
               add_x = hi_ff;
            end else begin
               add_x   = {hi_ff[ACC_WIDTH-2:0], ra_ff[ACC_WIDTH-1]};
               add_sub = 1'b1;
            end
         end
         U_FIX: begin
            add_y   = ra_ff;
            add_sub = 1'b1;
         end
         U_IDLE, U_DONE: begin
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      neg_in   = neg_ff;
      ovf_in   = ovf_ff;
      dz_in    = dz_ff;
      ra_in    = ra_ff;
      rb_in    = rb_ff;
      hi_in    = hi_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         U_IDLE: begin
            if (cmd.start) begin
               ra_in  = opa;
               rb_in  = opb;
               op_in  = cmd.op;
               neg_in = opa[ACC_WIDTH-1] ^ opb[ACC_WIDTH-1];
               ovf_in = 1'b0;
               dz_in  = 1'b0;
               unique case (cmd.op)
                  OP_ADD, OP_SUB: state_in = U_ARITH;
                  OP_MUL:         state_in = U_ABSA;
                  OP_DIV: begin
                     if (opb == '0) begin
                        dz_in    = 1'b1;
                        state_in = U_DONE;
                     end else begin
                        state_in = U_ABSA;
                     end
                  end
                  default: state_in = U_ARITH;
               endcase
            end
         end
         U_ARITH: begin
            ra_in    = add_sum[ACC_WIDTH-1:0];
            ovf_in   = arith_ovf;
            state_in = U_DONE;
         end
         U_ABSA: begin
            if (ra_ff[ACC_WIDTH-1]) begin
               ra_in = add_sum[ACC_WIDTH-1:0];
            end
            state_in = U_ABSB;
         end
         U_ABSB: begin
            if (rb_ff[ACC_WIDTH-1]) begin
               rb_in = add_sum[ACC_WIDTH-1:0];
            end
            hi_in    = '0;
            cnt_in   = '0;
            state_in = U_ITER;
         end
         U_ITER: begin
            if (op_ff == OP_MUL) begin
               if (ra_ff[0]) begin
                  {hi_in, ra_in} = {add_sum, ra_ff[ACC_WIDTH-1:1]};
               end else begin
                  {hi_in, ra_in} = {1'b0, hi_ff, ra_ff[ACC_WIDTH-1:1]};
               end
            end else begin
               hi_in = qbit ? add_sum[ACC_WIDTH-1:0]
                            : {hi_ff[ACC_WIDTH-2:0], ra_ff[ACC_WIDTH-1]};
               ra_in = {ra_ff[ACC_WIDTH-2:0], qbit};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(ACC_WIDTH - 1)) begin
               state_in = U_FIX;
            end
         end
         U_FIX: begin
            if (op_ff == OP_MUL) begin
               ovf_in = (hi_ff != '0) ||
                        (neg_ff ? (ra_ff[ACC_WIDTH-1] && (ra_ff[ACC_WIDTH-2:0] != '0))
                                : ra_ff[ACC_WIDTH-1]);
            end else begin
               ovf_in = !neg_ff && ra_ff[ACC_WIDTH-1];
            end
            if (neg_ff) begin
               ra_in = add_sum[ACC_WIDTH-1:0];
            end
            state_in = U_DONE;
         end
         U_DONE: begin
            state_in = U_IDLE;
         end
         default: begin
            state_in = U_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= U_IDLE;
      end else begin
         state_ff <= state_in;
      end
      op_ff  <= op_in;
      neg_ff <= neg_in;
      ovf_ff <= ovf_in;
      dz_ff  <= dz_in;
      ra_ff  <= ra_in;
      rb_ff  <= rb_in;
      hi_ff  <= hi_in;
      cnt_ff <= cnt_in;
   end

   assign sts.done = (state_ff == U_DONE);
   assign sts.ovf  = ovf_ff;
   assign sts.dz   = dz_ff;
   assign result   = ra_ff;

endmodule

// ===== hw/rtl/left_to_right_calculator_parser.sv =====
// left_to_right_calculator_parser: character parser, accumulator state and
// result register around the shared arithmetic unit
// depends on ltrc_pkg, ltrc_req_if, ltrc_rsp_if, ltrc_unit
//
//   channel | dir | handshake       | payload
//   req_if  | in  | valid / ready   | char_code[7:0]
//   rsp_if  | out | valid / ready   | value[63:0], divide_by_zero, overflow
//
// a digit never reaches the unit; add or subtract run ARITH and DONE;
// divide by zero goes to DONE; multiply or divide run ABSA, ABSB, ITER on the
// shared adder, one bit per cycle, FIX, DONE; emitting characters add T_EMIT
// req_if.ready is low while an operator is in the unit and while a result waits
// for a full result register
// synchronous reset clears accumulator, pending number, operator and flags

module left_to_right_calculator_parser #(
   parameter int ACC_WIDTH = 64
) (
   input  logic       clock,
   input  logic       reset,
   ltrc_req_if.sink   req_if,
   ltrc_rsp_if.source rsp_if
);
   import ltrc_pkg::*;

   localparam logic [ACC_WIDTH-1:0] MAX_POS = {1'b0, {(ACC_WIDTH-1){1'b1}}};

   typedef enum logic [2:0] {
      T_IDLE = 3'b001,
      T_CALC = 3'b010,
      T_EMIT = 3'b100
   } tstate_type;

   tstate_type             state_ff, state_in;
   logic [ACC_WIDTH-1:0]   acc_ff, acc_in;
   logic [ACC_WIDTH-1:0]   pend_ff, pend_in;
   op_type                 op_ff, op_in;
   op_type                 next_op_ff, next_op_in;
   logic                   emit_ff, emit_in;
   logic                   dz_seen_ff, dz_seen_in;
   logic                   ovf_seen_ff, ovf_seen_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [VALUE_WIDTH-1:0] rsp_value_ff, rsp_value_in;
   logic                   rsp_dz_ff, rsp_dz_in;
   logic                   rsp_ovf_ff, rsp_ovf_in;

   logic                   req_accept;
   logic                   req_digit;
   logic [3:0]             digit;
   logic [ACC_WIDTH+3:0]   ten_p;
   logic                   digit_ovf;
   logic signed [ACC_WIDTH-1:0] acc_s;
   unit_cmd_type           unit_cmd;
   unit_sts_type           unit_sts;
   logic [ACC_WIDTH-1:0]   unit_result;

   assign req_if.ready = (state_ff == T_IDLE);
   assign req_accept   = req_if.valid && req_if.ready;
   assign req_digit    = is_digit(req_if.char_code);
   assign digit        = 4'(req_if.char_code - CHAR_ZERO);

   // pending * 10 + digit, kept wide for the overflow compare
   assign ten_p = ((ACC_WIDTH+4)'(pend_ff) << 3) + ((ACC_WIDTH+4)'(pend_ff) << 1)
                + (ACC_WIDTH+4)'(digit);
   assign digit_ovf = ten_p > (ACC_WIDTH+4)'(MAX_POS);

   assign acc_s = acc_ff;

   assign unit_cmd.start = req_accept && !req_digit;
   assign unit_cmd.op    = op_ff;

   ltrc_unit #(
      .ACC_WIDTH (ACC_WIDTH)
   ) u_unit (
      .clock  (clock),
      .reset  (reset),
      .cmd    (unit_cmd),
      .opa    (acc_ff),
      .opb    (pend_ff),
      .sts    (unit_sts),
      .result (unit_result)
   );

   always_comb begin
      state_in     = state_ff;
      acc_in       = acc_ff;
      pend_in      = pend_ff;
      op_in        = op_ff;
      next_op_in   = next_op_ff;
      emit_in      = emit_ff;
      dz_seen_in   = dz_seen_ff;
      ovf_seen_in  = ovf_seen_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_value_in = rsp_value_ff;
      rsp_dz_in    = rsp_dz_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      unique case (state_ff)
         T_IDLE: begin
            if (req_accept) begin
               if (req_digit) begin
                  pend_in     = ten_p[ACC_WIDTH-1:0];
                  ovf_seen_in = ovf_seen_ff || digit_ovf;
               end else begin
                  emit_in = 1'b0;
                  priority if (req_if.char_code == CHAR_SUB) begin
                     next_op_in = OP_SUB;
                  end else if (req_if.char_code == CHAR_MUL) begin
                     next_op_in = OP_MUL;
                  end else if (req_if.char_code == CHAR_DIV) begin
                     next_op_in = OP_DIV;
                  end else if (req_if.char_code == CHAR_ADD) begin
                     next_op_in = OP_ADD;
                  end else begin
                     next_op_in = OP_ADD;
                     emit_in    = 1'b1;
                  end
                  state_in = T_CALC;
               end
            end
         end
         T_CALC: begin
            if (unit_sts.done) begin
               acc_in      = unit_result;
               pend_in     = '0;
               dz_seen_in  = dz_seen_ff || unit_sts.dz;
               ovf_seen_in = ovf_seen_ff || unit_sts.ovf;
               if (emit_ff) begin
                  state_in = T_EMIT;
               end else begin
                  op_in    = next_op_ff;
                  state_in = T_IDLE;
               end
            end
         end
         T_EMIT: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = VALUE_WIDTH'(acc_s);
               rsp_dz_in    = dz_seen_ff;
               rsp_ovf_in   = ovf_seen_ff;
               dz_seen_in   = 1'b0;
               ovf_seen_in  = 1'b0;
               op_in        = OP_ADD;
               state_in     = T_IDLE;
            end
         end
         default: begin
            state_in = T_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_IDLE;
         acc_ff       <= '0;
         pend_ff      <= '0;
         op_ff        <= OP_ADD;
         dz_seen_ff   <= 1'b0;
         ovf_seen_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         pend_ff      <= pend_in;
         op_ff        <= op_in;
         dz_seen_ff   <= dz_seen_in;
         ovf_seen_ff  <= ovf_seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      next_op_ff   <= next_op_in;
      emit_ff      <= emit_in;
      rsp_value_ff <= rsp_value_in;
      rsp_dz_ff    <= rsp_dz_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.value          = rsp_value_ff;
   assign rsp_if.divide_by_zero = rsp_dz_ff;
   assign rsp_if.overflow       = rsp_ovf_ff;

endmodule

// ===== hw/rtl/ltrc_checker.sv =====
// ltrc_checker: port-level assertions for the calculator parser, bound to
// the top level; depends on ltrc_pkg and left_to_right_calculator_parser

module ltrc_checker (
   input logic                                    clock,
   input logic                                    reset,
   input logic                                    req_valid,
   input logic                                    req_ready,
   input logic [ltrc_pkg::CHAR_WIDTH-1:0]         req_char_code,
   input logic                                    rsp_valid,
   input logic                                    rsp_ready,
   input logic signed [ltrc_pkg::VALUE_WIDTH-1:0] rsp_value
);
   import ltrc_pkg::*;

   logic req_accept;
   assign req_accept = req_valid && req_ready;

   // a digit sets only the pending number and overflow flag; stays ready
   a_digit_keeps_ready: assert property (@(posedge clock) disable iff (reset)
      req_accept && is_digit(req_char_code) |=> req_ready)
      else $error("ready dropped after a digit request");

   // any other character starts the arithmetic unit
   a_operator_busy: assert property (@(posedge clock) disable iff (reset)
      req_accept && !is_digit(req_char_code) |=> !req_ready)
      else $error("ready stayed high after an operator request");

   // a new result appears only at the end of a busy period
   a_result_after_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("result appeared without a preceding operator");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value))
      else $error("result dropped or changed while stalled");

endmodule

bind left_to_right_calculator_parser ltrc_checker u_ltrc_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_if.valid),
   .req_ready     (req_if.ready),
   .req_char_code (req_if.char_code),
   .rsp_valid     (rsp_if.valid),
   .rsp_ready     (rsp_if.ready),
   .rsp_value     (rsp_if.value)
);

// ===== bench/left_to_right_calculator_parser_tb.sv =====
// left_to_right_calculator_parser_tb: self-checking bench for the calculator parser,
// with a bit-accurate predictor of the accumulator, random stalls on both channels
// depends on ltrc_pkg, ltrc_req_if, ltrc_rsp_if, left_to_right_calculator_parser

module left_to_right_calculator_parser_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ltrc_pkg::*;

   localparam int RANDOM_CHARS = 900;
   localparam int SETTLE_CYCLES = VALUE_WIDTH + 16;
   localparam int STALL_LIMIT = 3000;
   localparam int HOLD_OFF_CYCLES = 400;

   localparam logic [CHAR_WIDTH-1:0] CHAR_NUL      = 8'h00;
   localparam logic [CHAR_WIDTH-1:0] CHAR_ALL_ONES = 8'hff;
   localparam logic [CHAR_WIDTH-1:0] CHAR_EQUALS   = 8'h3d;

   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0] value;
      logic                          divide_by_zero;
      logic                          overflow;
   } calc_result_type;

   logic clock;
   logic reset;

   ltrc_req_if req_if ();
   ltrc_rsp_if rsp_if ();

   left_to_right_calculator_parser #(
      .ACC_WIDTH(VALUE_WIDTH)
   ) u_dut (
      .clock (clock),
      .reset (reset),
      .req_if(req_if),
      .rsp_if(rsp_if)
   );

   // predicted calculator state
   logic [VALUE_WIDTH-1:0] acc_q;
   logic [VALUE_WIDTH-1:0] number_q;
   op_type                 op_q;
   logic                   dz_q;
   logic                   ovf_q;

   calc_result_type expected_emits[$];
   int  mismatch_count = 0;
   int  chars_accepted = 0;
   int  rsp_hold_cycles = 0;
   bit  req_gaps_on = 1'b0;
   bit  rsp_stalls_on = 1'b0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 80) begin
         return $urandom_range(1, 3);
      end else if (roll < 96) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 80);
   endfunction

   function automatic logic [CHAR_WIDTH-1:0] random_emit_char();
      logic [CHAR_WIDTH-1:0] c;
      do begin
         c = CHAR_WIDTH'($urandom_range(0, 255));
      end while ((c >= CHAR_ZERO && c <= CHAR_NINE) || c == CHAR_SUB || c == CHAR_MUL ||
                 c == CHAR_DIV || c == CHAR_ADD);
      return c;
   endfunction

   function automatic void clear_calc_state();
      acc_q = '0;
      number_q = '0;
      op_q = OP_ADD;
      dz_q = 1'b0;
      ovf_q = 1'b0;
   endfunction

   function automatic void apply_pending_op();
      logic [VALUE_WIDTH-1:0]   r;
      logic [VALUE_WIDTH-1:0]   mag_a;
      logic [VALUE_WIDTH-1:0]   mag_b;
      logic [VALUE_WIDTH-1:0]   quot;
      logic [2*VALUE_WIDTH-1:0] prod;
      logic                     neg;
      r = acc_q;
      case (op_q)
         OP_ADD: begin
            r = acc_q + number_q;
            if (acc_q[VALUE_WIDTH-1] == number_q[VALUE_WIDTH-1] &&
                r[VALUE_WIDTH-1] != acc_q[VALUE_WIDTH-1]) ovf_q = 1'b1;
         end
         OP_SUB: begin
            r = acc_q - number_q;
            if (acc_q[VALUE_WIDTH-1] != number_q[VALUE_WIDTH-1] &&
                r[VALUE_WIDTH-1] != acc_q[VALUE_WIDTH-1]) ovf_q = 1'b1;
         end
         OP_MUL: begin
            prod = {{VALUE_WIDTH{acc_q[VALUE_WIDTH-1]}}, acc_q} *
                   {{VALUE_WIDTH{number_q[VALUE_WIDTH-1]}}, number_q};
            r = prod[VALUE_WIDTH-1:0];
            if (prod[2*VALUE_WIDTH-1:VALUE_WIDTH] != {VALUE_WIDTH{prod[VALUE_WIDTH-1]}})
               ovf_q = 1'b1;
         end
         default: begin
            if (number_q == '0) begin
               dz_q = 1'b1;
            end else begin
               mag_a = acc_q[VALUE_WIDTH-1] ? -acc_q : acc_q;
               mag_b = number_q[VALUE_WIDTH-1] ? -number_q : number_q;
               quot = mag_a / mag_b;
               neg = acc_q[VALUE_WIDTH-1] ^ number_q[VALUE_WIDTH-1];
               r = neg ? -quot : quot;
               // only the most negative value over minus one gets here
               if (!neg && quot[VALUE_WIDTH-1]) ovf_q = 1'b1;
            end
         end
      endcase
      acc_q = r;
   endfunction

   function automatic void predict_char(input logic [CHAR_WIDTH-1:0] c);
      logic [VALUE_WIDTH-1:0] digit_val;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         digit_val = VALUE_WIDTH'(c - CHAR_ZERO);
         if (number_q > ({1'b0, {(VALUE_WIDTH-1){1'b1}}} - digit_val) / 10) ovf_q = 1'b1;
         number_q = number_q * 10 + digit_val;
         return;
      end
      apply_pending_op();
      number_q = '0;
      case (c)
         CHAR_SUB: op_q = OP_SUB;
         CHAR_MUL: op_q = OP_MUL;
         CHAR_DIV: op_q = OP_DIV;
         CHAR_ADD: op_q = OP_ADD;
         default: begin
            expected_emits.push_back('{value: acc_q, divide_by_zero: dz_q, overflow: ovf_q});
            dz_q = 1'b0;
            ovf_q = 1'b0;
            op_q = OP_ADD;
         end
      endcase
   endfunction

   task automatic send_char(input logic [CHAR_WIDTH-1:0] c);
      int gap;
      gap = 0;
      if (req_gaps_on && $urandom_range(0, 3) == 0) gap = pick_gap();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.char_code <= c;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      chars_accepted++;
      predict_char(c);
   endtask

   task automatic send_digits(input string s);
      foreach (s[i]) send_char(s[i]);
   endtask

   task automatic send_number(input int len);
      repeat (len) send_char(CHAR_ZERO + CHAR_WIDTH'($urandom_range(0, 9)));
   endtask

   task automatic wait_for_results();
      req_if.valid <= 1'b0;
      while (expected_emits.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic test_each_operator();
      send_digits("7");
      send_char(CHAR_SUB);
      send_digits("9");
      send_char(CHAR_MUL);
      send_digits("3");
      send_char(CHAR_DIV);
      send_digits("4");
      send_char(CHAR_ADD);
      send_digits("8");
      send_char(CHAR_NUL);
      send_digits("0");
      send_char(CHAR_ALL_ONES);
      wait_for_results();
   endtask

   task automatic test_divide_by_zero();
      send_digits("5");
      send_char(CHAR_DIV);
      send_char(CHAR_EQUALS);
      send_char(CHAR_EQUALS);
      wait_for_results();
   endtask

   // long numbers, most negative over minus one, wrapping subtract and multiply
   task automatic test_wrap_cases();
      send_char(CHAR_MUL);
      send_digits("0");
      send_char(CHAR_ADD);
      send_digits("9223372036854775808");
      send_char(CHAR_DIV);
      send_digits("18446744073709551615");
      send_char(CHAR_SUB);
      send_digits("1");
      send_char(CHAR_MUL);
      send_digits("2");
      send_char(CHAR_EQUALS);
      wait_for_results();
   endtask

   task automatic test_result_backpressure();
      req_gaps_on = 1'b0;
      rsp_hold_cycles = HOLD_OFF_CYCLES;
      repeat (6) begin
         send_number(1);
         send_char(CHAR_ADD);
         send_number(2);
         send_char(random_emit_char());
      end
      wait_for_results();
   endtask

   task automatic test_random_streams();
      int first_char;
      int ops;
      int roll;
      int len;
      int expr_count;
      first_char = chars_accepted;
      expr_count = 0;
      while (chars_accepted - first_char < RANDOM_CHARS) begin
         req_gaps_on = (expr_count % 30) < 20;
         rsp_stalls_on = (expr_count % 30) < 20;
         expr_count++;
         if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 5)) send_char(CHAR_WIDTH'($urandom_range(0, 255)));
         end
         ops = $urandom_range(0, 4);
         for (int k = 0; k <= ops; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < 10) len = 0;
            else if (roll < 85) len = $urandom_range(1, 4);
            else if (roll < 95) len = $urandom_range(5, 12);
            else len = $urandom_range(17, 20);
            send_number(len);
            if (k < ops) begin
               case ($urandom_range(0, 3))
                  0: send_char(CHAR_SUB);
                  1: send_char(CHAR_MUL);
                  2: send_char(CHAR_DIV);
                  default: send_char(CHAR_ADD);
               endcase
            end
         end
         send_char(random_emit_char());
      end
      wait_for_results();
   endtask

   initial begin : result_ready_driver
      int stall_left;
      stall_left = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_if.ready <= 1'b0;
            rsp_hold_cycles--;
         end else if (stall_left > 0) begin
            rsp_if.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_if.ready <= 1'b1;
            if (rsp_stalls_on && $urandom_range(0, 4) == 0) stall_left = pick_gap();
         end
      end
   end

   always @(posedge clock) begin : result_checker
      calc_result_type want;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         if (expected_emits.size() == 0) begin
            $display("%0t: unexpected result, expected none, got value %0d", $time,
                     rsp_if.value);
            mismatch_count++;
         end else begin
            want = expected_emits.pop_front();
            if (rsp_if.value !== want.value) begin
               $display("%0t: value expected %0d got %0d", $time, want.value, rsp_if.value);
               mismatch_count++;
            end
            if (rsp_if.divide_by_zero !== want.divide_by_zero) begin
               $display("%0t: divide_by_zero expected %0b got %0b", $time,
                        want.divide_by_zero, rsp_if.divide_by_zero);
               mismatch_count++;
            end
            if (rsp_if.overflow !== want.overflow) begin
               $display("%0t: overflow expected %0b got %0b", $time, want.overflow,
                        rsp_if.overflow);
               mismatch_count++;
            end
         end
      end
   end

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("%0t: no request or result moved for %0d cycles", $time, STALL_LIMIT);
      $display("CHECK FAILED");
      $finish;
   end

   initial begin : run_tests
      reset <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.char_code <= '0;
      clear_calc_state();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      req_gaps_on = 1'b1;
      rsp_stalls_on = 1'b1;
      test_each_operator();
      test_divide_by_zero();
      test_wrap_cases();
      test_result_backpressure();
      test_random_streams();
      if (mismatch_count == 0 && expected_emits.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
